// ----- rtl/matrix_multiply_defines.svh -----
// assertion macros for the matrix multiply block
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MM_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/mm_pkg.sv -----
// shared constants, types and helpers for the matrix multiply block
package mm_pkg;
    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int DIM_W    = 4;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 36;

    localparam logic [1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [1:0] FUNC_MULT    = 2'd2;

    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    // control handed down the cell chain
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_cell;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_ctl;

    function automatic logic [IDX_W-1:0] eff_max(input logic [DIM_W-1:0] reg_val);
        logic [IDX_W-1:0] res;
        if (reg_val == '0) begin
            res = '0;
        end else if (reg_val > DIM_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(reg_val - 1'b1);
        end
        return res;
    endfunction
endpackage

// ----- rtl/mm_store.sv -----
// element memory: one write port, one registered read port
module mm_store
    import mm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [ELEM_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [ELEM_W-1:0] o_rdata
);
    logic signed [ELEM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/mm_mul_cell.sv -----
// multiply cell: registered product of two elements, control handed on
module mm_mul_cell
    import mm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    output t_ctl                     o_ctl,
    output logic signed [PROD_W-1:0] o_prod
);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.first     <= i_ctl.first;
        o_ctl.last_k    <= i_ctl.last_k;
        o_ctl.last_cell <= i_ctl.last_cell;
        o_ctl.row       <= i_ctl.row;
        o_ctl.col       <= i_ctl.col;
        o_prod          <= i_a * i_b;
    end
endmodule

// ----- rtl/mm_acc_cell.sv -----
// accumulate cell: sums products of one result cell, emits at the last term
module mm_acc_cell
    import mm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [PROD_W-1:0] i_prod,
    output logic                     o_valid,
    output logic signed [SUM_W-1:0]  o_sum,
    output logic [IDX_W-1:0]         o_row,
    output logic [IDX_W-1:0]         o_col,
    output logic                     o_last
);
    logic signed [SUM_W-1:0] r_acc;
    logic signed [SUM_W-1:0] n_acc;

    always_comb begin
        n_acc = (i_ctl.first ? '0 : r_acc) + SUM_W'(i_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctl.valid && i_ctl.last_k;
        end
        if (i_ctl.valid) begin
            r_acc <= n_acc;
        end
        o_sum  <= n_acc;
        o_row  <= i_ctl.row;
        o_col  <= i_ctl.col;
        o_last <= i_ctl.last_cell;
    end
endmodule

// ----- rtl/matrix_multiply.sv -----
// matrix multiply top level: load stores, sequence and cell chain
// load items are accepted while idle; a multiply issues rows*cols*inner products,
// one multiply-accumulate per cycle while issue is not paused, through the read
// register, multiply cell and accumulate cell into the output queue
// results wait in a two-entry output queue; issue pauses while it could overflow
// i_rst_n synchronous active low; sizes reset to 8, stores are not cleared
module matrix_multiply
    import mm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_index[2:0], col_index[5:3], element_value[21:6], zero fill
    input  logic [23:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // product_value[35:0], out_row[38:36], out_col[41:39], zero fill
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
`include "matrix_multiply_defines.svh"

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    t_state           r_state;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic [IDX_W-1:0] mi, mk, mj;

    logic [1:0]              in_func;
    logic [IDX_W-1:0]        in_row, in_col;
    logic signed [ELEM_W-1:0] in_val;
    logic                    in_acc;

    logic signed [ELEM_W-1:0] a_rd, b_rd;
    t_ctl  r_rd_ctl, m_ctl, issue_ctl;
    logic signed [PROD_W-1:0] m_prod;

    logic                    acc_valid, acc_last;
    logic signed [SUM_W-1:0] acc_sum;
    logic [IDX_W-1:0]        acc_row, acc_col;

    // output queue
    logic [SUM_W+2*IDX_W:0]  r_q [2];
    logic                    r_qwp, r_qrp;
    logic [1:0]              r_qcnt;
    logic [2:0]              inflight;
    logic                    issue, pop;

    assign in_func = s_axis_tuser;
    assign in_row  = s_axis_tdata[2:0];
    assign in_col  = s_axis_tdata[5:3];
    assign in_val  = s_axis_tdata[21:6];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign mi = eff_max(r_rows);
    assign mk = eff_max(r_inner);
    assign mj = eff_max(r_cols);

    // results possibly in flight: read, multiply, accumulate stages and output queue
    assign inflight = 3'(r_rd_ctl.valid && r_rd_ctl.last_k)
                    + 3'(m_ctl.valid && m_ctl.last_k) + 3'(acc_valid) + 3'(r_qcnt);
    assign issue = (r_state == ST_RUN) && !((r_k == mk) && (inflight >= 3'd2) && !pop)
                 && !((r_k == mk) && (inflight >= 3'd3));

    always_comb begin
        issue_ctl.valid     = issue;
        issue_ctl.first     = (r_k == '0);
        issue_ctl.last_k    = (r_k == mk);
        issue_ctl.last_cell = (r_i == mi) && (r_j == mj);
        issue_ctl.row       = r_i;
        issue_ctl.col       = r_j;
    end

    mm_store u_a (
        .i_clk(i_clk),
        .i_we(in_acc && in_func == FUNC_WRITE_A),
        .i_waddr({in_row, in_col}), .i_wdata(in_val),
        .i_raddr({r_i, r_k}), .o_rdata(a_rd)
    );
    mm_store u_b (
        .i_clk(i_clk),
        .i_we(in_acc && in_func == FUNC_WRITE_B),
        .i_waddr({in_row, in_col}), .i_wdata(in_val),
        .i_raddr({r_k, r_j}), .o_rdata(b_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl.valid <= 1'b0;
        end else begin
            r_rd_ctl.valid <= issue_ctl.valid;
        end
        r_rd_ctl.first     <= issue_ctl.first;
        r_rd_ctl.last_k    <= issue_ctl.last_k;
        r_rd_ctl.last_cell <= issue_ctl.last_cell;
        r_rd_ctl.row       <= issue_ctl.row;
        r_rd_ctl.col       <= issue_ctl.col;
    end

    mm_mul_cell u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_rd_ctl),
        .i_a(a_rd), .i_b(b_rd), .o_ctl(m_ctl), .o_prod(m_prod)
    );
    mm_acc_cell u_acc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(m_ctl), .i_prod(m_prod),
        .o_valid(acc_valid), .o_sum(acc_sum), .o_row(acc_row), .o_col(acc_col),
        .o_last(acc_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(MAX_DIM);
            r_inner <= DIM_W'(MAX_DIM);
            r_cols  <= DIM_W'(MAX_DIM);
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS_A:    r_rows  <= i_cfg_data;
                    CFG_INNER_DIM: r_inner <= i_cfg_data;
                    CFG_COLS_B:    r_cols  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && in_func == FUNC_MULT) begin
                        r_state <= ST_RUN;
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (r_k != mk) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_k <= '0;
                            if (r_j != mj) begin
                                r_j <= r_j + 1'b1;
                            end else begin
                                r_j <= '0;
                                if (r_i != mi) begin
                                    r_i <= r_i + 1'b1;
                                end else begin
                                    r_state <= ST_IDLE;
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp  <= 1'b0;
            r_qrp  <= 1'b0;
            r_qcnt <= '0;
        end else begin
            if (acc_valid) begin
                r_qwp <= ~r_qwp;
            end
            if (pop) begin
                r_qrp <= ~r_qrp;
            end
            r_qcnt <= r_qcnt + 2'(acc_valid) - 2'(pop);
        end
        if (acc_valid) begin
            r_q[r_qwp] <= {acc_last, acc_col, acc_row, acc_sum};
        end
    end

    assign m_axis_tvalid = (r_qcnt != '0);
    assign m_axis_tdata  = {6'd0, r_q[r_qrp][SUM_W+2*IDX_W-1:0]};
    assign m_axis_tlast  = r_q[r_qrp][SUM_W+2*IDX_W];

    `MM_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, acc_valid && !pop, r_qcnt != 2'd2)
    `MM_ASSERT_IMP(a_busy_no_accept, i_clk, i_rst_n, r_state == ST_RUN, !s_axis_tready)
    `MM_ASSERT_NEXT(a_issue_reads, i_clk, i_rst_n, issue, r_rd_ctl.valid)
endmodule
